>>> design/pov_column_timing_controller_top_assert.svh
// Assertion macros for the POV column timing controller
`ifndef POV_COLUMN_TIMING_CONTROLLER_TOP_ASSERT_SVH
`define POV_COLUMN_TIMING_CONTROLLER_TOP_ASSERT_SVH

// implication checked outside reset
`define POVCT_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("povct check failed");

// next-cycle implication, also checked during reset
`define POVCT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("povct check failed");

`endif

>>> design/povct_pkg.sv
// ----------------------------------------------------------------------------
// povct_pkg
// Shared constants and helpers of the POV column timing controller.
// ----------------------------------------------------------------------------
`default_nettype none

package povct_pkg;

  localparam int unsigned COLUMN_COUNT = 128;
  localparam int unsigned IMAGE_COUNT  = 4;

  localparam logic [1:0] CMD_HALL = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_POLL = 2'd2;

  localparam logic [1:0] REG_PERIOD_MIN = 2'd0;
  localparam logic [1:0] REG_PERIOD_MAX = 2'd1;
  localparam logic [1:0] REG_AUTO_REVS  = 2'd2;
  localparam logic [1:0] REG_DEBOUNCE   = 2'd3;

  localparam logic [31:0] RPM_DIVIDEND = 32'd60000000;

  localparam int IN_W  = 40;
  localparam int OUT_W = 80;

  function automatic logic [3:0] next_image(input logic [3:0] img);
    logic [4:0] inc;
    inc = {1'b0, img} + 5'd1;
    if (inc >= 5'(IMAGE_COUNT)) next_image = 4'd0;
    else next_image = inc[3:0];
  endfunction

endpackage

`default_nettype wire

>>> design/pov_column_timing_controller_top.sv
// ----------------------------------------------------------------------------
// pov_column_timing_controller_top
// Timing core of a rotating POV display: revolution period, column timer
// compare value, column stepping, button debounce and image auto-advance.
// ----------------------------------------------------------------------------
// Flow: tick, poll and rejected Hall pulse pass through S_EXEC and S_FIN to output
//   valid; an accepted Hall pulse also runs two 32-step serial divides
//   (period/COLUMN_COUNT, then 60000000/period for rpm) via S_CMPU and S_RPM.
// Items: one at a time; a new transfer is taken only after the result is loaded
//   into the output register, which an output stall can delay.
// Reset (rst, synchronous): status state and m_tvalid cleared, button seen as
//   released, configuration back to 5000/200000/0/30000; data path not reset.
`default_nettype none

module pov_column_timing_controller_top
  import povct_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  output logic             s_tready,
  input  wire  [IN_W-1:0]  s_tdata,   // time_us[31:0], button_level[32], zero pad
  input  wire  [1:0]       s_tuser,   // command[1:0]
  output logic             m_tvalid,
  input  wire              m_tready,
  output logic [OUT_W-1:0] m_tdata,   // column_index[7:0], image_index[11:8],
                                      // stable[12], timer_running[13],
                                      // rev_period[45:14], compare_value[61:46],
                                      // rpm[77:62], zero pad
  output logic             m_tuser,   // column_valid
  input  wire              cfg_we,
  input  wire  [1:0]       cfg_index,
  input  wire  [31:0]      cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIVC = 3'd2;
  localparam logic [2:0] S_CMPU = 3'd3;
  localparam logic [2:0] S_DIVR = 3'd4;
  localparam logic [2:0] S_RPM  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]  state;
  logic [31:0] period_min, period_max;
  logic [15:0] auto_revs;
  logic [19:0] debounce;

  logic [1:0]  cmd;
  logic [31:0] now;
  logic        level;

  logic [31:0] last_hall, rev_period, rev_count, last_adv, press_start;
  logic [7:0]  col_cnt;
  logic        stable_flag, running, btn_prev, wait_rel;
  logic [15:0] compare, rpm;
  logic [3:0]  image;
  logic        res_valid;
  logic [7:0]  res_col;

  // serial restoring divider
  logic [31:0] rem;
  logic [31:0] dvd, dvs;
  logic [4:0]  step;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem, dvd[31]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign s_tready = (state == S_IDLE);

  logic [31:0] period;
  assign period = now - last_hall;

  always_ff @(posedge clk) begin
    logic [3:0] img;
    logic       pv;
    if (rst) begin
      state       <= S_IDLE;
      period_min  <= 32'd5000;
      period_max  <= 32'd200000;
      auto_revs   <= 16'd0;
      debounce    <= 20'd30000;
      last_hall   <= '0;
      rev_period  <= '0;
      rev_count   <= '0;
      last_adv    <= '0;
      press_start <= '0;
      col_cnt     <= '0;
      stable_flag <= 1'b0;
      running     <= 1'b0;
      btn_prev    <= 1'b1;
      wait_rel    <= 1'b0;
      compare     <= '0;
      rpm         <= '0;
      image       <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PERIOD_MIN: period_min <= cfg_data;
          REG_PERIOD_MAX: period_max <= cfg_data;
          REG_AUTO_REVS:  auto_revs  <= cfg_data[15:0];
          REG_DEBOUNCE:   debounce   <= cfg_data[19:0];
          default: ;
        endcase
      end
      // S_FIN owns m_tvalid while a result is being loaded
      if (m_tvalid && m_tready && state != S_FIN) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd   <= s_tuser;
            now   <= s_tdata[31:0];
            level <= s_tdata[32];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_valid <= 1'b0;
          res_col   <= '0;
          state     <= S_FIN;
          case (cmd)
            CMD_HALL: begin
              last_hall <= now;
              rev_count <= rev_count + 32'd1;
              if (period < period_min || period > period_max) begin
                stable_flag <= 1'b0;
                rev_period  <= '0;
                running     <= 1'b0;
                rpm         <= '0;
              end else begin
                stable_flag <= 1'b1;
                rev_period  <= period;
                col_cnt     <= '0;
                running     <= 1'b1;
                rem         <= '0;
                dvd         <= period;
                dvs         <= 32'(COLUMN_COUNT);
                step        <= '0;
                state       <= S_DIVC;
              end
            end
            CMD_TICK: begin
              if (running && {24'd0, col_cnt} < 32'(COLUMN_COUNT)) begin
                res_valid <= 1'b1;
                res_col   <= col_cnt;
                col_cnt   <= col_cnt + 8'd1;
              end
            end
            CMD_POLL: begin
              img = image;
              pv  = btn_prev;
              if (wait_rel) begin
                if (level) begin
                  wait_rel <= 1'b0;
                  pv = 1'b1;
                end
              end else begin
                if (!level && pv) press_start <= now;
                if (!level && !pv && (now - press_start) >= {12'd0, debounce}) begin
                  img = next_image(img);
                  wait_rel <= 1'b1;
                end
                pv = level;
              end
              btn_prev <= pv;
              if (auto_revs != 16'd0 && (rev_count - last_adv) >= {16'd0, auto_revs}) begin
                last_adv <= rev_count;
                img = next_image(img);
              end
              image <= img;
            end
            default: ;
          endcase
        end
        S_DIVC, S_DIVR: begin
          rem  <= ge ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
          dvd  <= {dvd[30:0], ge};
          step <= step + 5'd1;
          if (step == 5'd31) state <= (state == S_DIVC) ? S_CMPU : S_RPM;
        end
        S_CMPU: begin
          // ticks = 2*q clamped to 1..65535, stored minus one
          if (dvd[31:15] != '0)   compare <= 16'd65534;
          else if (dvd == '0)     compare <= 16'd0;
          else                    compare <= {dvd[14:0], 1'b0} - 16'd1;
          rem   <= '0;
          dvd   <= RPM_DIVIDEND;
          dvs   <= rev_period;
          step  <= '0;
          state <= S_DIVR;
        end
        S_RPM: begin
          // zero period (open window) reports zero rpm
          if (rev_period == '0)        rpm <= '0;
          else if (dvd[31:16] != '0)   rpm <= 16'hFFFF;
          else                         rpm <= dvd[15:0];
          state <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!m_tvalid || m_tready)) begin
      m_tuser <= res_valid;
      m_tdata <= {2'b00, rpm, compare, rev_period, running, stable_flag, image, res_col};
    end
  end

endmodule

`default_nettype wire

>>> design/povct_checker.sv
// ----------------------------------------------------------------------------
// povct_checker
// Port-level checks of the POV column timing controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pov_column_timing_controller_top_assert.svh"

module povct_checker
  import povct_pkg::*;
(
  input wire             clk,
  input wire             rst,
  input wire             m_tvalid,
  input wire             m_tready,
  input wire [OUT_W-1:0] m_tdata,
  input wire             m_tuser
);

  `POVCT_ASSERT_NEXT(a_reset_empty, rst, !m_tvalid)
  `POVCT_ASSERT_IMPL(a_col_range, m_tvalid && m_tuser, m_tdata[7:0] < 8'(COLUMN_COUNT))
  `POVCT_ASSERT_IMPL(a_unstable_zero, m_tvalid && !m_tdata[12], (m_tdata[45:14] == 32'd0) && (m_tdata[77:62] == 16'd0))
  `POVCT_ASSERT_NEXT(a_hold, !rst && m_tvalid && !m_tready, rst || m_tvalid)

endmodule

bind pov_column_timing_controller_top povct_checker u_povct_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the POV column timing controller: Hall pulses, column
// ticks and button polls go in, every status item coming out is checked
// against an in-bench model of the period window, column stepping, debounce
// and image auto-advance.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import povct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        col_valid;
    logic [7:0]  col_idx;
    logic [3:0]  img;
    logic        stable;
    logic        running;
    logic [31:0] period;
    logic [15:0] cmp;
    logic [15:0] rpm;
  } status_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic [1:0]       s_tuser = CMD_HALL;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = REG_PERIOD_MIN;
  logic [31:0]      cfg_data = '0;

  always #1 clk = ~clk;

  pov_column_timing_controller_top dut (.*);

  // model state
  logic [31:0] win_lo, win_hi, dbnc;
  logic [15:0] auto_revs;
  logic [31:0] last_hall, rev_per, revs, last_adv, press_t;
  logic [7:0]  col_cnt;
  logic        stab, run, btn_prev, wait_rel;
  logic [15:0] cmp_reg;
  logic [3:0]  cur_img;

  status_t     status_q[$];
  int          errors = 0;
  bit          quiet = 1'b0;
  logic [31:0] now_us = 0;
  int          stall_left = 0;

  function automatic logic [3:0] bump(input logic [3:0] i);
    return 4'((32'(i) + 1) % IMAGE_COUNT);
  endfunction

  task automatic model_item(input logic [1:0] cmd, input logic [31:0] t, input logic lvl);
    status_t     r;
    logic [31:0] p, tk;
    r = '0;
    if (cmd == CMD_HALL) begin
      p = t - last_hall;
      last_hall = t;
      revs = revs + 32'd1;
      if (p < win_lo || p > win_hi) begin
        stab = 0; rev_per = 0; run = 0;
      end else begin
        stab = 1; rev_per = p; col_cnt = 0; run = 1;
        tk = (p / COLUMN_COUNT) * 2;
        if (tk > 65535) tk = 65535;
        if (tk == 0) tk = 1;
        cmp_reg = 16'(tk - 1);
      end
    end else if (cmd == CMD_TICK) begin
      if (run && col_cnt < COLUMN_COUNT) begin
        r.col_valid = 1; r.col_idx = col_cnt; col_cnt = col_cnt + 8'd1;
      end
    end else if (cmd == CMD_POLL) begin
      if (wait_rel) begin
        if (lvl) begin
          wait_rel = 0; btn_prev = 1;
        end
      end else begin
        if (!lvl && btn_prev) press_t = t;
        if (!lvl && !btn_prev && (t - press_t) >= dbnc) begin
          cur_img = bump(cur_img); wait_rel = 1;
        end
        btn_prev = lvl;
      end
      if (auto_revs != 0 && (revs - last_adv) >= 32'(auto_revs)) begin
        last_adv = revs; cur_img = bump(cur_img);
      end
    end
    r.img = cur_img; r.stable = stab; r.running = run; r.period = rev_per;
    r.cmp = cmp_reg;
    if (rev_per != 0) begin
      tk = RPM_DIVIDEND / rev_per;
      r.rpm = (tk > 65535) ? 16'hFFFF : 16'(tk);
    end
    status_q.push_back(r);
  endtask

  task automatic send(input logic [1:0] cmd, input logic [31:0] t, input logic lvl);
    if (!quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 19)) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= IN_W'({lvl, t});
    do @(posedge clk); while (!s_tready);
    model_item(cmd, t, lvl);
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (status_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PERIOD_MIN: win_lo = v;
      REG_PERIOD_MAX: win_hi = v;
      REG_AUTO_REVS:  auto_revs = v[15:0];
      default:        dbnc = {12'd0, v[19:0]};
    endcase
    @(posedge clk);
  endtask

  // output side: random stall bursts on m_tready, none in quiet mode
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (quiet) m_tready <= 1'b1;
    else if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 18);
      m_tready <= 1'b0;
    end else m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    status_t e, a;
    if (!rst && m_tvalid && m_tready) begin
      a.col_valid = m_tuser;
      a.col_idx = m_tdata[7:0];   a.img = m_tdata[11:8];
      a.stable = m_tdata[12];     a.running = m_tdata[13];
      a.period = m_tdata[45:14];  a.cmp = m_tdata[61:46];
      a.rpm = m_tdata[77:62];
      if (status_q.size() == 0) begin
        $display("%0t unexpected transfer: actual %h", $time, a);
        errors++;
      end else begin
        e = status_q.pop_front();
        if (e !== a) begin
          $display("%0t mismatch: expected %h actual %h", $time, e, a);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send(CMD_TICK, 0, 1);                 // tick while stopped
    send(CMD_HALL, 32'd1000, 1);          // too short
    send(CMD_HALL, 32'd21000, 1);         // accepted
    repeat (3) send(CMD_TICK, 0, 1);
    send(CMD_POLL, 32'd21000, 0);         // press
    send(CMD_POLL, 32'd61000, 0);         // debounced advance
    send(CMD_POLL, 32'd62000, 0);         // waiting
    send(CMD_POLL, 32'd63000, 1);         // release
    send(2'd3, 32'hFFFF_FFFF, 1);         // unused command
    send(CMD_HALL, 32'hFFFF_FFFF, 0);     // huge period
    drain();
    write_reg(REG_PERIOD_MIN, 0);
    write_reg(REG_PERIOD_MAX, 32'hFFFF_FFFF);
    send(CMD_HALL, 32'hFFFF_FFFF, 0);     // zero period
    send(CMD_TICK, 0, 0);
    send(CMD_HALL, 32'h0FFF_FFFF, 0);     // compare clamps high
    send(CMD_HALL, 32'h0FFF_FFFF + 5, 0); // compare clamps low, rpm saturates
    send(CMD_HALL, 32'h0FFF_FFFF + 1005, 0); // rpm 60000, no saturation
    drain();
  endtask

  task automatic test_columns();
    int n;
    write_reg(REG_PERIOD_MIN, 2000);
    write_reg(REG_PERIOD_MAX, 300000);
    for (int r = 0; r < 4; r++) begin
      now_us += $urandom_range(1500, 320000);
      send(CMD_HALL, now_us, $urandom_range(0, 1));
      n = (r == 1) ? 135 : $urandom_range(0, 140);
      for (int i = 0; i < n; i++) send(CMD_TICK, $urandom, $urandom_range(0, 1));
    end
    drain();
  endtask

  task automatic test_empty_window();
    write_reg(REG_PERIOD_MIN, 100000);
    write_reg(REG_PERIOD_MAX, 99999);
    for (int i = 0; i < 10; i++) begin
      now_us += $urandom_range(50000, 150000);
      send(CMD_HALL, now_us, 1);
      send(CMD_TICK, now_us, 1);
    end
    drain();
  endtask

  task automatic test_random(input int count, input logic [15:0] revs_cfg,
                             input logic [31:0] db);
    int k;
    logic lvl;
    write_reg(REG_PERIOD_MIN, $urandom_range(1000, 20000));
    write_reg(REG_PERIOD_MAX, $urandom_range(60000, 400000));
    write_reg(REG_AUTO_REVS, {16'd0, revs_cfg});
    write_reg(REG_DEBOUNCE, db);
    lvl = 1;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 3) now_us = $urandom;
      else now_us += $urandom_range(0, 40000);
      if (k < 15) send(CMD_HALL, now_us, $urandom_range(0, 1));
      else if (k < 70) send(CMD_TICK, $urandom, $urandom_range(0, 1));
      else if (k < 97) begin
        if ($urandom_range(0, 3) == 0) lvl = ~lvl;
        send(CMD_POLL, now_us, lvl);
      end else send(2'd3, $urandom, $urandom_range(0, 1));
      if (i == count / 2) while (status_q.size() != 0) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    win_lo = 5000; win_hi = 200000; auto_revs = 0; dbnc = 30000;
    last_hall = 0; rev_per = 0; revs = 0; last_adv = 0; press_t = 0;
    col_cnt = 0; stab = 0; run = 0; btn_prev = 1; wait_rel = 0;
    cmp_reg = 0; cur_img = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_columns();
    test_empty_window();
    test_random(500, 0, 30000);
    test_random(400, 3, 0);
    test_random(300, 16'hFFFF, 1000000);
    test_random(200, 1, $urandom_range(0, 60000));
    quiet = 1'b1;
    test_random(200, 16'($urandom_range(1, 6)), 20000);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+design
design/povct_pkg.sv
design/pov_column_timing_controller_top.sv
design/povct_checker.sv
tb/tb_top.sv
